// ===== src/sme_pkg.sv =====
package sme_pkg;

  localparam int unsigned WordW = 64;

  // Opcodes of the instruction stream.
  localparam logic [4:0] OP_POP     = 5'd0;
  localparam logic [4:0] OP_PUSH_B  = 5'd1;
  localparam logic [4:0] OP_PUSH_H  = 5'd2;
  localparam logic [4:0] OP_PUSH_W  = 5'd3;
  localparam logic [4:0] OP_PUSH_D  = 5'd4;
  localparam logic [4:0] OP_LOAD    = 5'd5;
  localparam logic [4:0] OP_SAVE    = 5'd6;
  localparam logic [4:0] OP_ADD     = 5'd7;
  localparam logic [4:0] OP_SUB     = 5'd8;
  localparam logic [4:0] OP_MUL     = 5'd9;
  localparam logic [4:0] OP_DIV     = 5'd10;
  localparam logic [4:0] OP_JMP     = 5'd12;
  localparam logic [4:0] OP_TERM    = 5'd21;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_IGN   = 3'd4
  } status_e;

  // Work that remains after decode.
  typedef enum logic [2:0] {
    PATH_DONE = 3'd0,
    PATH_WB   = 3'd1,
    PATH_MUL  = 3'd2,
    PATH_DIV  = 3'd3,
    PATH_LOAD = 3'd4,
    PATH_SAVE = 3'd5
  } path_e;

  typedef struct packed {
    logic [4:0]        action;
    logic signed [63:0] immediate;
  } instr_t;

  typedef struct packed {
    logic signed [63:0] top_value;
    logic [8:0]         stack_depth;
    logic               jump_taken;
    logic [31:0]        jump_target;
    logic               finished;
    status_e            status;
  } result_t;

  typedef struct packed {
    logic accept;
    logic decode;
    logic mul;
    logic memop;
    logic wb;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic  clr_done;
    path_e path;
    logic  need_mod;
    logic  mul_done;
    logic  div_done;
    logic  out_free;
  } dp_stat_t;

endpackage

// ===== src/sme_stream_if.sv =====
interface sme_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/sme_div.sv =====
module sme_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quo_o,
  output logic [63:0] rem_o
);
  import sme_pkg::*;

  logic                     busy_q;
  logic                     done_q;
  logic [5:0]               cnt_q;
  logic [WordW-1:0]         q_q;
  logic [WordW-1:0]         r_q;
  logic [WordW-1:0]         d_q;
  logic [WordW:0]           r_sh;
  logic [WordW:0]           diff;

  // One restoring step per cycle.
  assign r_sh = {r_q, q_q[WordW-1]};
  assign diff = r_sh - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[WordW]) begin
        r_q <= diff[WordW-1:0];
        q_q <= {q_q[WordW-2:0], 1'b1};
      end else begin
        r_q <= r_sh[WordW-1:0];
        q_q <= {q_q[WordW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;
  assign rem_o  = r_q;
endmodule

// ===== src/sme_datapath.sv =====
module sme_datapath #(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned MEM_BYTES   = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sme_pkg::ctrl_cmd_t cmd_i,
  output sme_pkg::dp_stat_t  stat_o,
  input  sme_pkg::instr_t    instr_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output sme_pkg::result_t   out_data_o
);
  import sme_pkg::*;

  localparam int unsigned SpW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IxW   = $clog2(STACK_DEPTH);
  localparam int unsigned BaW   = $clog2(MEM_BYTES);
  localparam bit          IsPow2 = (MEM_BYTES & (MEM_BYTES - 1)) == 0;

  logic [63:0]    stack_q [STACK_DEPTH];
  logic [7:0]     bmem_q [MEM_BYTES];

  logic [4:0]     op_q;
  logic [63:0]    imm_q;
  logic [SpW-1:0] sp_q;
  logic [63:0]    top_q;
  logic [63:0]    rd_q;
  logic [63:0]    res_q;
  logic [63:0]    prod_q;
  logic [1:0]     mcnt_q;
  status_e        status_q;
  logic           jt_q;
  logic [31:0]    jtar_q;
  logic           fin_q;
  logic           div_neg_q;
  logic [BaW-1:0] mem_addr_q;
  logic [7:0]     brd_q;
  logic [BaW-1:0] clr_addr_q;
  logic           clr_done_q;
  logic           out_valid_q;
  result_t        out_q;

  logic [SpW-1:0] sp_m1, sp_m2;
  logic [SpW-1:0] in_sp_m2;
  path_e          path;
  status_e        dec_status;
  logic           dec_push;
  logic [63:0]    push_val;
  logic           st_we;
  logic [IxW-1:0] st_waddr;
  logic [63:0]    st_wdata;
  logic [IxW-1:0] st_raddr;
  logic [IxW-1:0] wb_addr;
  logic [63:0]    wb_data;
  logic           div_start;
  logic [63:0]    div_a, div_b;
  logic           div_done;
  logic [63:0]    div_quo, div_rem;
  logic [31:0]    mul_a, mul_b;
  logic           out_free;

  assign sp_m1    = sp_q - SpW'(1);
  assign sp_m2    = sp_q - SpW'(2);
  assign in_sp_m2 = sp_q - SpW'(2);

  // Push operand, sign-extended by push size.
  always_comb begin
    case (op_q)
      OP_PUSH_B: push_val = {{56{imm_q[7]}}, imm_q[7:0]};
      OP_PUSH_H: push_val = {{48{imm_q[15]}}, imm_q[15:0]};
      OP_PUSH_W: push_val = {{32{imm_q[31]}}, imm_q[31:0]};
      default:   push_val = imm_q;
    endcase
  end

  // Decode: fault check and the path the instruction takes.
  always_comb begin
    path       = PATH_DONE;
    dec_status = ST_OK;
    dec_push   = 1'b0;
    case (op_q)
      OP_POP, OP_JMP, OP_TERM: begin
        if (sp_q == '0) dec_status = ST_UNDER;
      end
      OP_PUSH_B, OP_PUSH_H, OP_PUSH_W, OP_PUSH_D: begin
        if (sp_q >= SpW'(STACK_DEPTH)) dec_status = ST_OVER;
        else dec_push = 1'b1;
      end
      OP_LOAD: begin
        if (sp_q == '0) dec_status = ST_UNDER;
        else path = PATH_LOAD;
      end
      OP_SAVE: begin
        if (sp_q < SpW'(2)) dec_status = ST_UNDER;
        else path = PATH_SAVE;
      end
      OP_ADD, OP_SUB: begin
        if (sp_q < SpW'(2)) dec_status = ST_UNDER;
        else path = PATH_WB;
      end
      OP_MUL: begin
        if (sp_q < SpW'(2)) dec_status = ST_UNDER;
        else path = PATH_MUL;
      end
      OP_DIV: begin
        if (sp_q < SpW'(2)) dec_status = ST_UNDER;
        else if (top_q == '0) dec_status = ST_DIVZ;
        else path = PATH_DIV;
      end
      default: dec_status = ST_IGN;
    endcase
  end

  // Stack memory: one write port, one registered read port.
  assign wb_addr  = (op_q == OP_LOAD) ? sp_m1[IxW-1:0] : sp_m2[IxW-1:0];
  assign wb_data  = (op_q == OP_LOAD) ? {56'd0, brd_q} : res_q;
  assign st_we    = (cmd_i.decode && dec_push) || cmd_i.wb;
  assign st_waddr = cmd_i.wb ? wb_addr : sp_q[IxW-1:0];
  assign st_wdata = cmd_i.wb ? wb_data : push_val;
  assign st_raddr = (instr_i.action == OP_TERM) ? '0 : in_sp_m2[IxW-1:0];

  always_ff @(posedge clk_i) begin
    if (st_we) stack_q[st_waddr] <= st_wdata;
    if (cmd_i.accept) rd_q <= stack_q[st_raddr];
  end

  // Byte memory: cleared entry by entry after reset.
  always_ff @(posedge clk_i) begin
    if (!clr_done_q) bmem_q[clr_addr_q] <= 8'd0;
    else if (cmd_i.memop && op_q == OP_SAVE) bmem_q[mem_addr_q] <= rd_q[7:0];
    if (cmd_i.memop && op_q == OP_LOAD) brd_q <= bmem_q[mem_addr_q];
  end

  // Shared divider: signed quotient, or the address modulo the memory size.
  assign div_start = cmd_i.decode && (path == PATH_DIV ||
                     (!IsPow2 && (path == PATH_LOAD || path == PATH_SAVE)));
  assign div_a = (op_q == OP_DIV) ? (rd_q[63] ? 64'd0 - rd_q : rd_q) : top_q;
  assign div_b = (op_q == OP_DIV) ? (top_q[63] ? 64'd0 - top_q : top_q)
                                  : 64'(MEM_BYTES);

  sme_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // 32x32 partial products; only the low 64 bits of the product are kept.
  always_comb begin
    case (mcnt_q)
      2'd0:    begin mul_a = rd_q[31:0];  mul_b = top_q[31:0];  end
      2'd1:    begin mul_a = rd_q[31:0];  mul_b = top_q[63:32]; end
      default: begin mul_a = rd_q[63:32]; mul_b = top_q[31:0];  end
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= instr_i.action;
      imm_q <= instr_i.immediate;
    end
    if (cmd_i.decode) begin
      status_q   <= dec_status;
      jt_q       <= 1'b0;
      jtar_q     <= '0;
      fin_q      <= 1'b0;
      mcnt_q     <= '0;
      mem_addr_q <= top_q[BaW-1:0];
      div_neg_q  <= rd_q[63] ^ top_q[63];
      if (dec_status == ST_OK) begin
        case (op_q)
          OP_POP: top_q <= rd_q;
          OP_PUSH_B, OP_PUSH_H, OP_PUSH_W, OP_PUSH_D: top_q <= push_val;
          OP_ADD: res_q <= rd_q + top_q;
          OP_SUB: res_q <= rd_q - top_q;
          OP_JMP: begin
            jt_q   <= 1'b1;
            jtar_q <= top_q[31:0];
            top_q  <= rd_q;
          end
          OP_TERM: fin_q <= 1'b1;
          default: ;
        endcase
      end
    end
    if (cmd_i.mul) begin
      mcnt_q <= mcnt_q + 2'd1;
      prod_q <= mul_a * mul_b;
      if (mcnt_q == 2'd1) res_q <= prod_q;
      else if (mcnt_q != 2'd0) res_q <= res_q + {prod_q[31:0], 32'd0};
    end
    if (div_done) begin
      if (op_q == OP_DIV) res_q <= div_neg_q ? 64'd0 - div_quo : div_quo;
      else mem_addr_q <= div_rem[BaW-1:0];
    end
    if (cmd_i.memop && op_q == OP_SAVE) top_q <= rd_q;
    if (cmd_i.wb) top_q <= wb_data;
    if (cmd_i.finish && out_free) begin
      out_q.top_value   <= fin_q ? rd_q : ((sp_q != '0) ? top_q : 64'd0);
      out_q.stack_depth <= 9'(sp_q);
      out_q.jump_taken  <= jt_q;
      out_q.jump_target <= jtar_q;
      out_q.finished    <= fin_q;
      out_q.status      <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      clr_addr_q  <= '0;
      clr_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!clr_done_q) begin
        clr_addr_q <= clr_addr_q + BaW'(1);
        if (clr_addr_q == BaW'(MEM_BYTES - 1)) clr_done_q <= 1'b1;
      end
      if (cmd_i.decode && dec_status == ST_OK) begin
        case (op_q)
          OP_POP, OP_JMP: sp_q <= sp_m1;
          OP_PUSH_B, OP_PUSH_H, OP_PUSH_W, OP_PUSH_D: sp_q <= sp_q + SpW'(1);
          OP_TERM: sp_q <= '0;
          default: ;
        endcase
      end
      if (cmd_i.memop && op_q == OP_SAVE) sp_q <= sp_m1;
      if (cmd_i.wb && op_q != OP_LOAD) sp_q <= sp_m1;
      if (cmd_i.finish && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign stat_o.clr_done = clr_done_q;
  assign stat_o.path     = path;
  assign stat_o.need_mod = !IsPow2;
  assign stat_o.mul_done = (mcnt_q == 2'd3);
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

// ===== src/sme_ctrl.sv =====
module sme_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sme_pkg::dp_stat_t  stat_i,
  output sme_pkg::ctrl_cmd_t cmd_o
);
  import sme_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_DECODE = 9'b000000100,
    S_MUL    = 9'b000001000,
    S_DIV    = 9'b000010000,
    S_MEMOP  = 9'b000100000,
    S_WB     = 9'b001000000,
    S_DONE   = 9'b010000000,
    S_SPARE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (stat_i.clr_done) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        case (stat_i.path)
          PATH_WB:   state_d = S_WB;
          PATH_MUL:  state_d = S_MUL;
          PATH_DIV:  state_d = S_DIV;
          PATH_LOAD, PATH_SAVE: state_d = stat_i.need_mod ? S_DIV : S_MEMOP;
          default:   state_d = S_DONE;
        endcase
      end
      S_MUL: if (stat_i.mul_done) state_d = S_WB;
      S_DIV: begin
        if (stat_i.div_done) state_d = (stat_i.path == PATH_DIV) ? S_WB : S_MEMOP;
      end
      S_MEMOP: state_d = (stat_i.path == PATH_LOAD) ? S_WB : S_DONE;
      S_WB:    state_d = S_DONE;
      S_DONE:  if (stat_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign cmd_o.accept = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.decode = (state_q == S_DECODE);
  assign cmd_o.mul    = (state_q == S_MUL);
  assign cmd_o.memop  = (state_q == S_MEMOP);
  assign cmd_o.wb     = (state_q == S_WB);
  assign cmd_o.finish = (state_q == S_DONE);
endmodule

// ===== src/stack_machine_execute_unit.sv =====
// Steps: an accepted instruction word is decoded, then its result word is registered;
// save adds a byte-memory step, load that and a stack write-back, add and sub a write-back,
// mul a multiply step and a write-back, and div the iterative radix-2 divider and a write-back.
// When MEM_BYTES is not a power of two, load and save first pass through the divider too.
// Only one instruction is in flight at a time. Reset: asynchronous, active low; the stack
// empties at once, then the byte memory is cleared byte by byte before the first word is taken.
module stack_machine_execute_unit #(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned MEM_BYTES   = 4096
) (
  input logic         clk_i,
  input logic         rst_ni,
  sme_stream_if.sink   in_i,
  sme_stream_if.source out_o
);
  import sme_pkg::*;

  // The controller sequences each instruction through decode, optional
  // multiply, divide or byte-memory steps, and a stack write-back where needed. The datapath
  // holds the stack (with a cached top word), the byte memory and the units.
  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  sme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The result sits in an output register, so a new instruction word can be
  // accepted while the previous result word still waits downstream.
  sme_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .MEM_BYTES   (MEM_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .instr_i     (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

  assign in_i.ready = in_ready;

  // No instruction is taken before the byte memory is cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> stat.clr_done)
    else $error("instruction accepted during clearing pass");

  // Only one instruction is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second instruction accepted while busy");

  // A finished program leaves an empty stack and no fault.
  a_term_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.finished) |->
      (out_o.data.stack_depth == 9'd0 && out_o.data.status == ST_OK))
    else $error("term result with nonempty stack or fault");

  // A jump is never reported with a fault or together with term.
  a_jump_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.jump_taken) |->
      (out_o.data.status == ST_OK && !out_o.data.finished))
    else $error("jump reported with fault or term");
endmodule

// ===== bench/tb_stack_machine_execute_unit.sv =====
module tb_stack_machine_execute_unit;
  import sme_pkg::*;

  localparam int unsigned StackDepth = 256;
  localparam int unsigned MemBytes   = 4096;
  // Cycles without any accepted word before the run is declared hung. The
  // limit covers the clearing pass after reset and a divide, and a stalling
  // receiver may hold a result for a while on top of that.
  localparam int unsigned HangLimit  = 20000;

  // Predicts the result word of each instruction and checks it against the
  // result words that come out of the block, oldest first.
  class exec_scoreboard;
    logic [63:0] stack_q[StackDepth];
    int unsigned depth;
    logic [7:0]  mem_q[MemBytes];
    result_t     pending_q[$];
    int unsigned errors;

    function new();
      depth  = 0;
      errors = 0;
      foreach (mem_q[i]) mem_q[i] = '0;
    endfunction

    function automatic logic [63:0] sign_ext(logic [63:0] v, int unsigned bits);
      logic [63:0] mask;
      if (bits >= 64) return v;
      mask = (64'd1 << bits) - 64'd1;
      v &= mask;
      if (v[bits-1]) v |= ~mask;
      return v;
    endfunction

    // Executes one accepted instruction on the shadow state.
    function void note_instr(instr_t ins);
      result_t     r;
      int unsigned bits;
      logic [63:0] a, b;
      r        = '0;
      r.status = ST_OK;
      bits     = 0;
      case (ins.action)
        OP_POP: if (depth < 1) r.status = ST_UNDER; else depth--;
        OP_PUSH_B: bits = 8;
        OP_PUSH_H: bits = 16;
        OP_PUSH_W: bits = 32;
        OP_PUSH_D: bits = 64;
        OP_LOAD: begin
          if (depth < 1) r.status = ST_UNDER;
          else stack_q[depth-1] = {56'd0, mem_q[stack_q[depth-1] % MemBytes]};
        end
        OP_SAVE: begin
          if (depth < 2) r.status = ST_UNDER;
          else begin
            mem_q[stack_q[depth-1] % MemBytes] = stack_q[depth-2][7:0];
            depth--;
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (depth < 2) r.status = ST_UNDER;
          else begin
            a = stack_q[depth-2];
            b = stack_q[depth-1];
            if (ins.action == OP_DIV && b == 0) r.status = ST_DIVZ;
            else begin
              case (ins.action)
                OP_ADD: a = a + b;
                OP_SUB: a = a - b;
                OP_MUL: a = a * b;
                default: a = (a == 64'h8000_0000_0000_0000 && b == '1) ? a
                             : 64'($signed(a) / $signed(b));
              endcase
              stack_q[depth-2] = a;
              depth--;
            end
          end
        end
        OP_JMP: begin
          if (depth < 1) r.status = ST_UNDER;
          else begin
            r.jump_taken  = 1'b1;
            r.jump_target = stack_q[depth-1][31:0];
            depth--;
          end
        end
        OP_TERM: begin
          if (depth < 1) r.status = ST_UNDER;
          else begin
            r.finished  = 1'b1;
            r.top_value = stack_q[0];
            depth       = 0;
            pending_q.push_back(r);
            return;
          end
        end
        default: r.status = ST_IGN;
      endcase
      if (bits != 0) begin
        if (depth >= StackDepth) r.status = ST_OVER;
        else begin
          stack_q[depth] = sign_ext(ins.immediate, bits);
          depth++;
        end
      end
      r.top_value   = (depth > 0) ? stack_q[depth-1] : '0;
      r.stack_depth = 9'(depth);
      pending_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending_q.size() == 0) begin
        $error("result word with no instruction outstanding");
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.top_value !== exp.top_value) begin
        $error("top_value expected %h got %h", exp.top_value, got.top_value);
        errors++;
      end
      if (got.stack_depth !== exp.stack_depth) begin
        $error("stack_depth expected %0d got %0d", exp.stack_depth, got.stack_depth);
        errors++;
      end
      if (got.jump_taken !== exp.jump_taken) begin
        $error("jump_taken expected %b got %b", exp.jump_taken, got.jump_taken);
        errors++;
      end
      if (got.jump_target !== exp.jump_target) begin
        $error("jump_target expected %h got %h", exp.jump_target, got.jump_target);
        errors++;
      end
      if (got.finished !== exp.finished) begin
        $error("finished expected %b got %b", exp.finished, got.finished);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status expected %0d got %0d", exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sme_stream_if #(.T(instr_t))  instr_if ();
  sme_stream_if #(.T(result_t)) result_if ();

  stack_machine_execute_unit #(
    .STACK_DEPTH(StackDepth),
    .MEM_BYTES  (MemBytes)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (instr_if.sink),
    .out_o (result_if.source)
  );

  exec_scoreboard sb;

  // Percent chance, per cycle, that the sender idles or the receiver stalls.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;
  int unsigned model_depth;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // The receiver takes its ready decision at each rising edge. Results are
  // sampled on the same edge they are accepted, before any new drive lands.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) sb.check_result(result_if.data);
      result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: counts cycles with no word moving on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (instr_if.valid && instr_if.ready)
        || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HangLimit) begin
        $display("stack_machine_execute_unit verification failed");
        $finish;
      end
    end
  end

  // Sends one instruction word, with random idle cycles in front of it, and
  // records it in the scoreboard once the block takes it.
  task automatic send_instr(logic [4:0] action, logic [63:0] imm);
    instr_t ins;
    ins.action    = action;
    ins.immediate = imm;
    while ($urandom_range(99) < send_idle_pct) begin
      instr_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    instr_if.valid <= 1'b1;
    instr_if.data  <= ins;
    @(posedge clk_i);
    while (!instr_if.ready) @(posedge clk_i);
    sb.note_instr(ins);
    model_depth = sb.depth;
  endtask

  // Random 64-bit value that often lands on an edge of the number range.
  function automatic logic [63:0] rand_word();
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(MemBytes * 2));
      2: return '1;
      3: return 64'h8000_0000_0000_0000;
      4: return 64'h7fff_ffff_ffff_ffff;
      default: return 64'($signed($urandom_range(40)) - 20);
    endcase
  endfunction

  // Picks an opcode that mostly keeps the stack working: pushes when
  // shallow, arithmetic and stores when deep, and now and then a fault.
  function automatic logic [4:0] rand_action();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3) return 5'($urandom_range(31));
    if (pick < 5) return OP_TERM;
    if (model_depth < 3 || pick < 40) return 5'($urandom_range(OP_PUSH_B, OP_PUSH_D));
    case ($urandom_range(8))
      0: return OP_POP;
      1: return OP_LOAD;
      2: return OP_SAVE;
      3: return OP_ADD;
      4: return OP_SUB;
      5: return OP_MUL;
      6: return OP_DIV;
      7: return OP_JMP;
      default: return OP_PUSH_D;
    endcase
  endfunction

  initial begin
    int unsigned phase;
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    model_depth    = 0;
    quiet_cycles   = 0;
    instr_if.valid = 1'b0;
    instr_if.data  = '0;
    rst_ni         = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: underflow on pop, term and add, sign extension at each
    // push size, the most negative word divided by minus one, divide by zero,
    // memory address wrap, jump, term, and the ignored opcodes.
    send_instr(OP_POP, '0);
    send_instr(OP_TERM, '0);
    send_instr(OP_ADD, '0);
    send_instr(5'd11, '1);
    send_instr(5'd31, '0);
    send_instr(OP_PUSH_B, 64'h0000_0000_0000_0080);
    send_instr(OP_PUSH_H, 64'h1234_5678_9abc_8000);
    send_instr(OP_PUSH_W, 64'hffff_ffff_7fff_ffff);
    send_instr(OP_PUSH_D, 64'h8000_0000_0000_0000);
    send_instr(OP_PUSH_D, '1);
    send_instr(OP_DIV, '0);
    send_instr(OP_PUSH_D, '0);
    send_instr(OP_DIV, '0);
    send_instr(OP_POP, '0);
    send_instr(OP_PUSH_D, 64'hffff_ffff_ffff_f0a5);
    send_instr(OP_SAVE, '0);
    send_instr(OP_PUSH_D, 64'(MemBytes) + 64'ha5);
    send_instr(OP_LOAD, '0);
    send_instr(OP_MUL, '0);
    send_instr(OP_SUB, '0);
    send_instr(OP_JMP, '0);
    send_instr(OP_TERM, '0);

    // Random part in four idling phases. The first phase fills the stack to
    // the top once so that overflow is seen; each phase then runs random programs.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if (phase == 0) begin
        while (model_depth < StackDepth) send_instr(OP_PUSH_D, {$urandom, $urandom});
        send_instr(OP_PUSH_B, '1);
        send_instr(OP_TERM, '0);
      end
      repeat (400) send_instr(rand_action(), rand_word());
    end

    instr_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("stack_machine_execute_unit verification clean");
    end else begin
      $display("stack_machine_execute_unit verification failed");
    end
    $finish;
  end

endmodule
